FILE: rtl/core/gbc_pkg.sv
// ----------------------------------------------------------------------------
// gbc_pkg
// Shared types, S-box table and round helpers for the GOST 28147-89 core.
// ----------------------------------------------------------------------------
package gbc_pkg;

    localparam int unsigned NUM_ROUNDS = 32;
    localparam int unsigned NUM_KEYS   = 8;
    localparam int unsigned ROT_LEFT   = 11;

    // Halves carried between rounds: a is the half written last, b the other
    typedef struct packed {
        logic        dec;
        logic [31:0] a;
        logic [31:0] b;
    } stage_t;

    typedef logic [NUM_KEYS-1:0][31:0] key_bank_t;

    // GOST R 34.11-94 test parameter set; row 0 acts on the lowest nibble
    localparam logic [3:0] SBOX [8][16] = '{
        '{4'd4,  4'd10, 4'd9,  4'd2,  4'd13, 4'd8,  4'd0,  4'd14,
          4'd6,  4'd11, 4'd1,  4'd12, 4'd7,  4'd15, 4'd5,  4'd3},
        '{4'd14, 4'd11, 4'd4,  4'd12, 4'd6,  4'd13, 4'd15, 4'd10,
          4'd2,  4'd3,  4'd8,  4'd1,  4'd0,  4'd7,  4'd5,  4'd9},
        '{4'd5,  4'd8,  4'd1,  4'd13, 4'd10, 4'd3,  4'd4,  4'd2,
          4'd14, 4'd15, 4'd12, 4'd7,  4'd6,  4'd0,  4'd9,  4'd11},
        '{4'd7,  4'd13, 4'd10, 4'd1,  4'd0,  4'd8,  4'd9,  4'd15,
          4'd14, 4'd4,  4'd6,  4'd12, 4'd11, 4'd2,  4'd5,  4'd3},
        '{4'd6,  4'd12, 4'd7,  4'd1,  4'd5,  4'd15, 4'd13, 4'd8,
          4'd4,  4'd10, 4'd9,  4'd14, 4'd0,  4'd3,  4'd11, 4'd2},
        '{4'd4,  4'd11, 4'd10, 4'd0,  4'd7,  4'd2,  4'd1,  4'd13,
          4'd3,  4'd6,  4'd8,  4'd5,  4'd9,  4'd12, 4'd15, 4'd14},
        '{4'd13, 4'd11, 4'd4,  4'd1,  4'd3,  4'd15, 4'd5,  4'd9,
          4'd0,  4'd10, 4'd14, 4'd7,  4'd6,  4'd8,  4'd2,  4'd12},
        '{4'd1,  4'd15, 4'd13, 4'd0,  4'd5,  4'd7,  4'd10, 4'd4,
          4'd9,  4'd2,  4'd3,  4'd14, 4'd6,  4'd11, 4'd8,  4'd12}
    };

    // Nibble substitution followed by rotate left by 11
    function automatic logic [31:0] round_fn(input logic [31:0] x);
        logic [31:0] s;
        s = '0;
        for (int n = 0; n < 8; n++) begin
            s[4*n +: 4] = SBOX[n][x[4*n +: 4]];
        end
        return {s[31-ROT_LEFT:0], s[31:32-ROT_LEFT]};
    endfunction

    // Key schedule: encrypt 0..7 three times then 7..0
    function automatic logic [2:0] enc_key_idx(input logic [4:0] rnd);
        return (rnd < 5'd24) ? rnd[2:0] : 3'd7 - rnd[2:0];
    endfunction

    // Key schedule: decrypt 0..7 once then 7..0 three times
    function automatic logic [2:0] dec_key_idx(input logic [4:0] rnd);
        return (rnd < 5'd8) ? rnd[2:0] : 3'd7 - rnd[2:0];
    endfunction

endpackage

FILE: rtl/core/gost_block_cipher_core.sv
// ----------------------------------------------------------------------------
// gost_block_cipher_core
// GOST 28147-89 block cipher, ECB core, 32 rounds unrolled into 32 stages.
// ----------------------------------------------------------------------------
//  Channel | Direction | Ports                         | Contents
//  --------+-----------+-------------------------------+---------------------
//  s_      | in        | s_tvalid s_tready s_tdata     | block, encrypt/decrypt
//          |           | s_tuser                       |
//  m_      | out       | m_tvalid m_tready m_tdata     | result block
//  cfg_    | in        | cfg_we cfg_index cfg_wdata    | subkey words 0..7
//
//  One item per cycle sustained while m_ does not stall; each round stage is registered.
//  The last round stage is the output register.
//  Reset (aresetn low, synchronous) clears all stage valids and the subkeys.
//  A stall on m_ freezes every stage together; s_tready drops in that cycle.
// ----------------------------------------------------------------------------
module gost_block_cipher_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [63:0] data_in
    input  logic        s_tuser,   // [0] action: 0 encrypt, 1 decrypt
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] data_out
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    localparam int unsigned NR = gbc_pkg::NUM_ROUNDS;

    gbc_pkg::key_bank_t key_words;
    gbc_pkg::stage_t    stage [NR+1];
    logic               valid [NR+1];
    logic               advance;

    // whole pipe moves unless the output holds an item not yet taken
    assign advance  = !valid[NR] || m_tready;
    assign s_tready = advance;

    gbc_key_regs u_keys (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .key_words (key_words)
    );

    // entry: N1 low half, N2 high half
    assign valid[0]     = s_tvalid;
    assign stage[0].dec = s_tuser;
    assign stage[0].a   = s_tdata[31:0];
    assign stage[0].b   = s_tdata[63:32];

    for (genvar r = 0; r < NR; r++) begin : g_round
        localparam logic [2:0] KE = gbc_pkg::enc_key_idx(5'(r));
        localparam logic [2:0] KD = gbc_pkg::dec_key_idx(5'(r));

        gbc_round u_round (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .in_valid  (valid[r]),
            .in_stage  (stage[r]),
            .key_enc   (key_words[KE]),
            .key_dec   (key_words[KD]),
            .out_valid (valid[r+1]),
            .out_stage (stage[r+1])
        );
    end

    // after the last round a holds N2 and b holds N1
    assign m_tvalid = valid[NR];
    assign m_tdata  = {stage[NR].a, stage[NR].b};

endmodule

FILE: rtl/core/gbc_key_regs.sv
// ----------------------------------------------------------------------------
// gbc_key_regs
// Eight 32-bit subkey registers behind a plain write port.
// ----------------------------------------------------------------------------
module gbc_key_regs (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_wdata,
    output gbc_pkg::key_bank_t key_words
);

    gbc_pkg::key_bank_t key_reg;
    gbc_pkg::key_bank_t key_next;

    // write decode
    always_comb begin
        key_next = key_reg;
        if (cfg_we) begin
            key_next[cfg_index] = cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= '0;
        end else begin
            key_reg <= key_next;
        end
    end

    assign key_words = key_reg;

endmodule

FILE: rtl/core/gbc_round.sv
// ----------------------------------------------------------------------------
// gbc_round
// One Feistel round and its pipeline register.
// ----------------------------------------------------------------------------
module gbc_round (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  logic             in_valid,
    input  gbc_pkg::stage_t  in_stage,
    input  logic [31:0]      key_enc,
    input  logic [31:0]      key_dec,
    output logic             out_valid,
    output gbc_pkg::stage_t  out_stage
);

    logic            valid_reg;
    gbc_pkg::stage_t stage_reg;
    gbc_pkg::stage_t stage_next;
    logic [31:0]     key_sel;
    logic [31:0]     sum;

    // add subkey, substitute and rotate, fold into the other half, swap
    always_comb begin
        key_sel          = in_stage.dec ? key_dec : key_enc;
        sum              = in_stage.a + key_sel;
        stage_next.dec   = in_stage.dec;
        stage_next.a     = in_stage.b ^ gbc_pkg::round_fn(sum);
        stage_next.b     = in_stage.a;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            stage_reg <= stage_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

FILE: rtl/core/gbc_checker.sv
// ----------------------------------------------------------------------------
// gbc_checker
// Port-level checks on the cipher core, bound to the top level.
// ----------------------------------------------------------------------------
module gbc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // input side is open exactly when the output can move
    a_ready_link: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not follow the output stall");

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a result leaves only when taken
    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(m_tvalid) |-> $past(m_tready) || !$past(aresetn))
        else $error("result dropped without handshake");

endmodule

bind gost_block_cipher_core gbc_checker u_gbc_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);
